[rtl/core/snt_pkg.sv]
package snt_pkg;

  localparam int OP_W       = 3;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int REL_W      = 5;
  localparam int REF_W      = 16;

  localparam logic [OP_W-1:0] OP_EMIT        = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE_SRC = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd2;
  localparam logic [OP_W-1:0] OP_READ        = 3'd3;
  localparam logic [OP_W-1:0] OP_HOLDS       = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

  localparam logic [7:0] NO_ENTRY = 8'hFF;

  typedef struct packed {
    logic [7:0] source;
    logic [6:0] note;
    logic [3:0] channel;
  } entry_t;

endpackage

[rtl/core/snt_table.sv]
module snt_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  snt_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output snt_pkg::entry_t rdata
);
  import snt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sounding_note_tracker.sv]
// order: emit and operations without a scan go from dispatch to status (a read through
// check); scans go from dispatch through a scan and a check state per table entry, then
// the end of scan, then status (a holds match goes from check straight to status)
// flow: one operation at a time, the next is taken the cycle after the status
// transaction is loaded; output stalls can hold dispatch, check and status
// reset: entry count and refusal counter cleared, table contents undefined until
// written, no clearing pass
module sounding_note_tracker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_port, source, note, velocity, channel, entry_index
  input  logic [snt_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [snt_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // event_port, event_channel, event_note, event_velocity, entry_source,
  // released_count, accepted, found, refusal_total
  output logic [snt_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [snt_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import snt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CHECK,
    S_STATUS
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [REF_W-1:0] refusal_r;
  logic [CW-1:0]   idx_i_r;
  logic [CW-1:0]   idx_w_r;
  logic [CW-1:0]   rel_r;
  logic            acc_r;
  logic            found_r;

  logic [OP_W-1:0] op_r;
  logic [7:0]      port_r;
  logic [7:0]      src_r;
  logic [6:0]      note_r;
  logic [6:0]      vel_r;
  logic [3:0]      chan_r;
  logic [7:0]      eidx_r;
  logic [7:0]      rd_src_r;
  logic [7:0]      rd_note_r;
  logic [3:0]      rd_chan_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic                  out_last_r;

  logic          can_put;
  logic          put_status;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          idx_in_range;
  logic          src_match;
  logic [6:0]    vel_on;
  logic          put_event;
  logic [KIND_W-1:0] ev_kind;
  entry_t        ev_entry;
  logic [6:0]    ev_vel;

  snt_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign can_put      = !out_valid_r || out_tready;
  assign put_status   = state_r == S_STATUS && can_put;
  assign idx_in_range = eidx_r < 8'(count_r);
  assign src_match    = mem_rdata.source == src_r;
  assign vel_on       = (vel_r == 7'd0) ? 7'd1 : vel_r;
  assign mem_raddr    = (op_r == OP_READ) ? eidx_r[AW-1:0] : idx_i_r[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_w_r[AW-1:0];
    mem_wdata = mem_rdata;
    if (state_r == S_DISPATCH && op_r == OP_EMIT && count_r < DEPTH_C && can_put) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[AW-1:0];
      mem_wdata = '{source: src_r, note: note_r, channel: chan_r};
    end else if (state_r == S_CHECK && op_r == OP_RELEASE_SRC && !src_match) begin
      mem_we = 1'b1;
    end
  end

  // event transaction to load this cycle
  always_comb begin
    put_event = 1'b0;
    ev_kind   = KIND_NOTE_OFF;
    ev_entry  = mem_rdata;
    ev_vel    = 7'd0;
    if (state_r == S_DISPATCH && op_r == OP_EMIT && count_r < DEPTH_C && can_put) begin
      put_event = 1'b1;
      ev_kind   = KIND_NOTE_ON;
      ev_entry  = '{source: src_r, note: note_r, channel: chan_r};
      ev_vel    = vel_on;
    end else if (state_r == S_CHECK && can_put &&
                 ((op_r == OP_RELEASE_SRC && src_match) || op_r == OP_RELEASE_ALL)) begin
      put_event = 1'b1;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      refusal_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !put_event && !put_status) begin
        out_valid_r <= 1'b0;
      end
      if (put_event) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= ev_kind;
        out_last_r  <= 1'b0;
        out_data_r  <= {6'd0, refusal_r, 1'b0, 1'b0, REL_W'(0), ev_entry.source, ev_vel,
                        1'b0, ev_entry.note, ev_entry.channel, port_r};
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r      <= in_tuser;
            port_r    <= in_tdata[7:0];
            src_r     <= in_tdata[15:8];
            note_r    <= in_tdata[22:16];
            vel_r     <= in_tdata[29:23];
            chan_r    <= in_tdata[33:30];
            eidx_r    <= in_tdata[41:34];
            rd_src_r  <= NO_ENTRY;
            rd_note_r <= NO_ENTRY;
            rd_chan_r <= 4'd0;
            idx_i_r   <= '0;
            idx_w_r   <= '0;
            rel_r     <= '0;
            acc_r     <= 1'b0;
            found_r   <= 1'b0;
            state_r   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op_r)
            OP_EMIT: begin
              if (count_r >= DEPTH_C) begin
                refusal_r <= refusal_r + REF_W'(1);
                state_r   <= S_STATUS;
              end else if (can_put) begin
                count_r <= count_r + CW'(1);
                acc_r   <= 1'b1;
                state_r <= S_STATUS;
              end
            end
            OP_RELEASE_SRC, OP_RELEASE_ALL, OP_HOLDS: state_r <= S_SCAN;
            OP_READ: state_r <= idx_in_range ? S_CHECK : S_STATUS;
            default: state_r <= S_STATUS;
          endcase
        end
        S_SCAN: begin
          // read of entry idx_i_r issued here, data valid in check
          if (idx_i_r < count_r) begin
            state_r <= S_CHECK;
          end else begin
            if (op_r == OP_RELEASE_SRC) begin
              count_r <= idx_w_r;
            end else if (op_r == OP_RELEASE_ALL) begin
              count_r <= '0;
            end
            state_r <= S_STATUS;
          end
        end
        S_CHECK: begin
          case (op_r)
            OP_RELEASE_SRC: begin
              if (!src_match) begin
                idx_w_r <= idx_w_r + CW'(1);
                idx_i_r <= idx_i_r + CW'(1);
                state_r <= S_SCAN;
              end else if (can_put) begin
                rel_r   <= rel_r + CW'(1);
                idx_i_r <= idx_i_r + CW'(1);
                state_r <= S_SCAN;
              end
            end
            OP_RELEASE_ALL: begin
              if (can_put) begin
                rel_r   <= rel_r + CW'(1);
                idx_i_r <= idx_i_r + CW'(1);
                state_r <= S_SCAN;
              end
            end
            OP_HOLDS: begin
              if (src_match) begin
                found_r <= 1'b1;
                state_r <= S_STATUS;
              end else begin
                idx_i_r <= idx_i_r + CW'(1);
                state_r <= S_SCAN;
              end
            end
            OP_READ: begin
              rd_src_r  <= mem_rdata.source;
              rd_note_r <= {1'b0, mem_rdata.note};
              rd_chan_r <= mem_rdata.channel;
              state_r   <= S_STATUS;
            end
            default: state_r <= S_STATUS;
          endcase
        end
        S_STATUS: begin
          if (put_status) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_STATUS;
            out_last_r  <= 1'b1;
            if (op_r == OP_READ) begin
              out_data_r <= {6'd0, refusal_r, found_r, acc_r, REL_W'(rel_r), rd_src_r, 7'd0,
                             rd_note_r, rd_chan_r, 8'd0};
            end else begin
              out_data_r <= {6'd0, refusal_r, found_r, acc_r, REL_W'(rel_r), 8'd0, 7'd0,
                             8'd0, 4'd0, 8'd0};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import snt_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int REFUSE_BURST = 6;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [7:0] port;
    logic [7:0] source;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] channel;
    logic [7:0] entry_index;
  } note_op_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [7:0] port;
    logic [3:0] channel;
    logic [7:0] note;
    logic [6:0] velocity;
    logic [7:0] source;
    logic [REL_W-1:0] released;
    logic accepted;
    logic found;
    logic [REF_W-1:0] refusals;
    logic last;
  } note_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic out_tlast;

  note_op_t pending_ops[$];
  note_result_t expected_results[$];

  entry_t held_notes[DEPTH];
  int held_count = 0;
  logic [REF_W-1:0] refusal_count = '0;

  note_op_t driven_op;
  note_result_t seen, wanted;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int mismatches = 0;
  bit quiet = 1'b0;
  bit done = 1'b0;

  sounding_note_tracker #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic note_op_t make_op(input int op, input int port, input int source,
                                       input int note, input int velocity,
                                       input int channel, input int entry_index);
    note_op_t o;
    o.op = OP_W'(op);
    o.port = 8'(port);
    o.source = 8'(source);
    o.note = 7'(note);
    o.velocity = 7'(velocity);
    o.channel = 4'(channel);
    o.entry_index = 8'(entry_index);
    return o;
  endfunction

  function automatic note_op_t random_op();
    int r;
    int op;
    int source;
    int entry_index;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_EMIT;
    else if (r < 55) op = OP_RELEASE_SRC;
    else if (r < 60) op = OP_RELEASE_ALL;
    else if (r < 75) op = OP_READ;
    else if (r < 93) op = OP_HOLDS;
    else op = $urandom_range(5, 7);
    // a small pool of sources so releases hit several entries
    if ($urandom_range(0, 3) == 0) source = $urandom_range(0, 255);
    else source = $urandom_range(0, 3);
    if ($urandom_range(0, 4) == 0) entry_index = $urandom_range(0, 255);
    else entry_index = $urandom_range(0, DEPTH + 1);
    return make_op(op, $urandom_range(0, 255), source, $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 15), entry_index);
  endfunction

  function automatic note_result_t note_event(input logic [KIND_W-1:0] kind,
                                              input logic [7:0] port, input entry_t e,
                                              input logic [6:0] velocity);
    note_result_t r;
    r = '{default: '0};
    r.kind = kind;
    r.port = port;
    r.channel = e.channel;
    r.note = {1'b0, e.note};
    r.velocity = velocity;
    r.source = e.source;
    r.refusals = refusal_count;
    return r;
  endfunction

  task automatic track_operation(input note_op_t o);
    note_result_t status;
    int i;
    int released;
    status = '{default: '0};
    released = 0;
    case (o.op)
      OP_EMIT: begin
        if (held_count >= DEPTH) begin
          refusal_count++;
        end else begin
          held_notes[held_count] = '{source: o.source, note: o.note, channel: o.channel};
          held_count++;
          expected_results.push_back(note_event(KIND_NOTE_ON, o.port,
            held_notes[held_count-1], (o.velocity == 0) ? 7'd1 : o.velocity));
          status.accepted = 1'b1;
        end
      end
      OP_RELEASE_SRC: begin
        i = 0;
        while (i < held_count) begin
          if (held_notes[i].source != o.source) begin
            i++;
          end else begin
            expected_results.push_back(note_event(KIND_NOTE_OFF, o.port, held_notes[i], 7'd0));
            for (int j = i; j + 1 < held_count; j++) held_notes[j] = held_notes[j+1];
            held_count--;
            released++;
          end
        end
      end
      OP_RELEASE_ALL: begin
        for (i = 0; i < held_count; i++)
          expected_results.push_back(note_event(KIND_NOTE_OFF, o.port, held_notes[i], 7'd0));
        released = held_count;
        held_count = 0;
      end
      OP_READ: begin
        if (o.entry_index < held_count) begin
          status.source = held_notes[o.entry_index].source;
          status.note = {1'b0, held_notes[o.entry_index].note};
          status.channel = held_notes[o.entry_index].channel;
        end else begin
          status.source = NO_ENTRY;
          status.note = NO_ENTRY;
        end
      end
      OP_HOLDS: begin
        for (i = 0; i < held_count; i++)
          if (held_notes[i].source == o.source) status.found = 1'b1;
      end
      default: begin
      end
    endcase
    status.kind = KIND_STATUS;
    status.released = REL_W'(released);
    status.refusals = refusal_count;
    status.last = 1'b1;
    expected_results.push_back(status);
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) track_operation(driven_op);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_ops.size() > 0) begin
          driven_op = pending_ops.pop_front();
          in_tdata <= {6'd0, driven_op.entry_index, driven_op.channel, driven_op.velocity,
                       driven_op.note, driven_op.source, driven_op.port};
          in_tuser <= driven_op.op;
          in_tvalid <= 1'b1;
          send_gap <= draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          wanted = expected_results.pop_front();
          seen.kind = out_tuser;
          seen.port = out_tdata[7:0];
          seen.channel = out_tdata[11:8];
          seen.note = out_tdata[19:12];
          seen.velocity = out_tdata[26:20];
          seen.source = out_tdata[34:27];
          seen.released = out_tdata[39:35];
          seen.accepted = out_tdata[40];
          seen.found = out_tdata[41];
          seen.refusals = out_tdata[57:42];
          seen.last = out_tlast;
          check_field("kind", seen.kind, wanted.kind);
          check_field("event_port", seen.port, wanted.port);
          check_field("event_channel", seen.channel, wanted.channel);
          check_field("event_note", seen.note, wanted.note);
          check_field("event_velocity", seen.velocity, wanted.velocity);
          check_field("entry_source", seen.source, wanted.source);
          check_field("released_count", seen.released, wanted.released);
          check_field("accepted", seen.accepted, wanted.accepted);
          check_field("found", seen.found, wanted.found);
          check_field("refusal_total", seen.refusals, wanted.refusals);
          check_field("last", seen.last, wanted.last);
          check_field("tdata padding", out_tdata[63:58], 0);
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_n);
    while (!done && idle_cycles < STALL_LIMIT) @(posedge clk);
    if (!done) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table
    pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_HOLDS, 0, 0, 0, 0, 0, 0));
    // fill to capacity, zero velocity first
    pending_ops.push_back(make_op(OP_EMIT, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_EMIT, 255, 255, 127, 127, 15, 255));
    for (int k = 0; k < DEPTH - 2; k++)
      pending_ops.push_back(make_op(OP_EMIT, $urandom_range(0, 255), (k % 3 == 0) ? 0 :
                                    (k % 3 == 1) ? 7 : 255, $urandom_range(0, 127),
                                    $urandom_range(1, 127), $urandom_range(0, 15), 0));
    pending_ops.push_back(make_op(OP_EMIT, 1, 9, 60, 100, 3, 0));
    drain();

    // refusals on a full table, no idling
    quiet = 1'b1;
    for (int k = 0; k < REFUSE_BURST; k++)
      pending_ops.push_back(make_op(OP_EMIT, $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 127), $urandom_range(0, 127),
                                    $urandom_range(0, 15), $urandom_range(0, 255)));
    drain();
    quiet = 1'b0;

    pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 0, 0, DEPTH - 1));
    pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 0, 0, DEPTH));
    pending_ops.push_back(make_op(OP_HOLDS, 0, 7, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_HOLDS, 0, 100, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_RELEASE_SRC, 200, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_RELEASE_ALL, 255, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(5, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(7, 255, 255, 127, 127, 15, 255));
    drain();

    for (int seg = 0; seg < 4; seg++) begin
      quiet = (seg == 2);
      for (int k = 0; k < 18; k++) pending_ops.push_back(random_op());
      drain();
    end
    quiet = 1'b0;

    done = 1'b1;
    repeat (60) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
